[rtl/dfa_pkg.sv]
// Shared types and constants of the decimal float to ASCII formatter.
// Used by the channel interfaces and the top level; depends on nothing.
package dfa_pkg;

	localparam int MANT_W     = 64;
	localparam int EXP_W      = 10;
	localparam int CHAR_W     = 7;
	localparam int NDIG       = 20;
	localparam int BCD_W      = 4 * NDIG;
	localparam int CNT_W      = 5;
	localparam int MAX_DIGITS = 16;
	localparam int NSEG       = 10;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
	localparam logic [CHAR_W-1:0] CH_E     = 7'h65;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_NORM,
		ST_PLAN,
		ST_EXP,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		SG_SIGN,
		SG_LEAD0,
		SG_INT,
		SG_TZERO,
		SG_POINT,
		SG_FZERO,
		SG_FRAC,
		SG_ECH,
		SG_EMINUS,
		SG_EDIG
	} seg_t;

endpackage

[rtl/dfa_in_if.sv]
// Input channel of the formatter: valid/ready plus mantissa and exponent.
// Depends on dfa_pkg for the field widths.
interface dfa_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [dfa_pkg::MANT_W-1:0] mantissa;
	logic signed [dfa_pkg::EXP_W-1:0]  exponent;

	modport source (output valid, output mantissa, output exponent, input ready);
	modport sink   (input valid, input mantissa, input exponent, output ready);
endinterface

[rtl/dfa_out_if.sv]
// Output channel of the formatter: valid/ready plus one character per item.
// Depends on dfa_pkg for the field widths.
interface dfa_out_if;
	logic                        valid;
	logic                        ready;
	logic [dfa_pkg::CHAR_W-1:0]  char_code;
	logic                        last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[rtl/decimal_float_to_ascii.sv]
// Top level of the decimal float to ASCII formatter.
// Depends on dfa_pkg, dfa_in_if and dfa_out_if.
//
// Usage:
//   din  takes one number per item: a signed 64-bit mantissa and a signed
//        10-bit power of ten. din.ready is high only while the block is idle.
//   dout gives the text one ASCII character per item; last_char marks the
//        final character of the number.
// Sequence:
//   A zero mantissa skips conversion and goes straight to output: one character.
//   Otherwise a shift-add-3 binary to BCD unit converts one bit per cycle,
//   then a digit scan trims the zeros, then the set-up states ST_PLAN
//   and ST_EXP run, then one character per cycle (up to 26) while
//   dout.ready allows it.
//   The next item is accepted as soon as the last character sits in the
//   output register.
// Reset: arst_n clears the sequencer and the output valid at once.
// Stall: while dout.ready is low the output register holds its character
//   and the character sequencer waits; nothing is dropped.
module decimal_float_to_ascii (
	input  logic       clk,
	input  logic       arst_n,
	dfa_in_if.sink     din,
	dfa_out_if.source  dout
);
	import dfa_pkg::*;

	localparam logic signed [11:0] MAXS = 12'(MAX_DIGITS);

	state_t                 state_q, state_d;
	logic [MANT_W-1:0]      bin_q;
	logic [BCD_W-1:0]       dig_q, tzr_q;
	logic [5:0]             conv_cnt_q;
	logic                   neg_q;
	logic signed [EXP_W-1:0] exp_q;
	logic [CNT_W-1:0]       nd_q, tz_q;
	logic [CNT_W-1:0]       a_q, zt_q, z2_q, b_q;
	logic [1:0]             ne_q;
	logic [9:0]             e2abs_q;
	logic [11:0]            ebcd_q;
	logic [NSEG-1:0]        pres_q;
	seg_t                   seg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   ov_q, last_q;
	logic [CHAR_W-1:0]      char_q;

	logic [MANT_W-1:0]      mag;
	logic                   emit_en, emit_last, norm_done;
	logic                   nxt_found, first_found;
	seg_t                   nxt_seg, first_seg;
	logic [CHAR_W-1:0]      emit_char;
	logic [11:0]            ebcd_raw, ebcd_al;
	logic [1:0]             ne_d;

	logic signed [11:0]     es, tot, e2;
	logic                   sci;
	logic [CNT_W-1:0]       p5, ls, k0;
	logic [CNT_W-1:0]       a_d, zt_d, z2_d, b_d;
	logic [NSEG-1:0]        pres_d;
	logic [9:0]             e2abs_d;

	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] v, input logic b);
		logic [BCD_W-1:0] adj;
		adj = v;
		for (int i = 0; i < NDIG; i++) begin
			if (v[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = v[4*i +: 4] + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], b};
	endfunction

	function automatic logic [11:0] bcd10(input logic [9:0] v);
		logic [11:0] r;
		r = '0;
		for (int i = 9; i >= 0; i--) begin
			for (int j = 0; j < 3; j++) begin
				if (r[4*j +: 4] >= 4'd5) begin
					r[4*j +: 4] = r[4*j +: 4] + 4'd3;
				end
			end
			r = {r[10:0], v[i]};
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] seg_count(input seg_t s,
		input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] zt,
		input logic [CNT_W-1:0] z2, input logic [CNT_W-1:0] b, input logic [1:0] ne);
		logic [CNT_W-1:0] c;
		case (s)
			SG_INT:   c = a;
			SG_TZERO: c = zt;
			SG_FZERO: c = z2;
			SG_FRAC:  c = b;
			SG_EDIG:  c = {{(CNT_W-2){1'b0}}, ne};
			default:  c = CNT_W'(1);
		endcase
		return c;
	endfunction

	assign mag = din.mantissa[MANT_W-1] ? (~din.mantissa + MANT_W'(1)) : din.mantissa;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (din.valid) begin
					state_d = (din.mantissa == '0) ? ST_EMIT : ST_CONV;
				end
			end
			ST_CONV: begin
				if (conv_cnt_q == 6'd63) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (norm_done) begin
					state_d = ST_PLAN;
				end
			end
			ST_PLAN: state_d = ST_EXP;
			ST_EXP:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_en && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and sequencer decode
	always_comb begin
		din.ready   = (state_q == ST_IDLE);
		emit_en     = (state_q == ST_EMIT) && (!ov_q || dout.ready);
		norm_done   = (dig_q[BCD_W-1 -: 4] != 4'd0) && (tzr_q[3:0] != 4'd0);
		nxt_found   = 1'b0;
		nxt_seg     = SG_SIGN;
		first_found = 1'b0;
		first_seg   = SG_SIGN;
		for (int k = 0; k < NSEG; k++) begin
			if (!nxt_found && pres_q[k] && (k > int'(seg_q))) begin
				nxt_found = 1'b1;
				nxt_seg   = seg_t'(4'(k));
			end
			if (!first_found && pres_q[k]) begin
				first_found = 1'b1;
				first_seg   = seg_t'(4'(k));
			end
		end
		emit_last = (cnt_q <= CNT_W'(1)) && !nxt_found;
		case (seg_q)
			SG_SIGN, SG_EMINUS: emit_char = CH_MINUS;
			SG_INT, SG_FRAC:    emit_char = CH_ZERO + {3'b000, dig_q[BCD_W-1 -: 4]};
			SG_POINT:           emit_char = CH_POINT;
			SG_ECH:             emit_char = CH_E;
			SG_EDIG:            emit_char = CH_ZERO + {3'b000, ebcd_q[11:8]};
			default:            emit_char = CH_ZERO;
		endcase
		dout.valid     = ov_q;
		dout.char_code = char_q;
		dout.last_char = last_q;
	end

	// layout of the text
	always_comb begin
		es      = {{2{exp_q[EXP_W-1]}}, exp_q};
		tot     = es + $signed({7'b0, nd_q});
		e2      = tot - 12'sd1;
		e2abs_d = e2[11] ? 10'(-e2) : e2[9:0];
		sci     = (exp_q != '0) && ((tot > MAXS) || (-es > MAXS));
		p5      = CNT_W'(-es);
		ls      = nd_q - CNT_W'(1) - tz_q;
		k0      = nd_q - p5;
		a_d     = '0;
		zt_d    = '0;
		z2_d    = '0;
		b_d     = '0;
		pres_d  = '0;
		pres_d[SG_SIGN] = neg_q;
		if (exp_q == '0) begin
			a_d = nd_q;
		end else if (sci) begin
			a_d = CNT_W'(1);
			b_d = ls;
			if (e2 != 12'sd0) begin
				pres_d[SG_ECH]    = 1'b1;
				pres_d[SG_EMINUS] = e2[11];
				pres_d[SG_EDIG]   = 1'b1;
			end
		end else if (exp_q[EXP_W-1]) begin
			if (nd_q > p5) begin
				a_d = k0;
				b_d = (ls >= k0) ? (ls - k0 + CNT_W'(1)) : '0;
			end else begin
				pres_d[SG_LEAD0] = 1'b1;
				z2_d = p5 - nd_q;
				b_d  = ls + CNT_W'(1);
			end
		end else begin
			a_d  = nd_q;
			zt_d = CNT_W'(exp_q);
		end
		pres_d[SG_INT]   = (a_d != '0);
		pres_d[SG_TZERO] = (zt_d != '0);
		pres_d[SG_POINT] = (b_d != '0);
		pres_d[SG_FZERO] = (z2_d != '0);
		pres_d[SG_FRAC]  = (b_d != '0);

		ebcd_raw = bcd10(e2abs_q);
		if (ebcd_raw[11:8] != 4'd0) begin
			ne_d    = 2'd3;
			ebcd_al = ebcd_raw;
		end else if (ebcd_raw[7:4] != 4'd0) begin
			ne_d    = 2'd2;
			ebcd_al = {ebcd_raw[7:0], 4'd0};
		end else begin
			ne_d    = 2'd1;
			ebcd_al = {ebcd_raw[3:0], 8'd0};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ov_q       <= 1'b0;
			seg_q      <= SG_SIGN;
			cnt_q      <= '0;
			pres_q     <= '0;
			conv_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (emit_en) begin
				ov_q <= 1'b1;
			end else if (dout.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					conv_cnt_q <= '0;
					if (din.valid) begin
						pres_q <= NSEG'(1) << SG_LEAD0;
						seg_q  <= SG_LEAD0;
						cnt_q  <= CNT_W'(1);
					end
				end
				ST_CONV: conv_cnt_q <= conv_cnt_q + 6'd1;
				ST_PLAN: pres_q <= pres_d;
				ST_EXP: begin
					seg_q <= first_seg;
					cnt_q <= seg_count(first_seg, a_q, zt_q, z2_q, b_q, ne_q);
				end
				ST_EMIT: begin
					if (emit_en) begin
						if (cnt_q > CNT_W'(1)) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end else if (nxt_found) begin
							seg_q <= nxt_seg;
							cnt_q <= seg_count(nxt_seg, a_q, zt_q, z2_q, b_q, ne_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (emit_en) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
		case (state_q)
			ST_IDLE: begin
				bin_q <= mag;
				neg_q <= din.mantissa[MANT_W-1];
				exp_q <= din.exponent;
				dig_q <= '0;
				tzr_q <= '0;
				nd_q  <= CNT_W'(NDIG);
				tz_q  <= '0;
			end
			ST_CONV: begin
				dig_q <= dd_step(dig_q, bin_q[MANT_W-1]);
				tzr_q <= dd_step(dig_q, bin_q[MANT_W-1]);
				bin_q <= {bin_q[MANT_W-2:0], 1'b0};
			end
			ST_NORM: begin
				if (dig_q[BCD_W-1 -: 4] == 4'd0) begin
					dig_q <= {dig_q[BCD_W-5:0], 4'd0};
					nd_q  <= nd_q - CNT_W'(1);
				end
				if (tzr_q[3:0] == 4'd0) begin
					tzr_q <= {4'd0, tzr_q[BCD_W-1:4]};
					tz_q  <= tz_q + CNT_W'(1);
				end
			end
			ST_PLAN: begin
				a_q     <= a_d;
				zt_q    <= zt_d;
				z2_q    <= z2_d;
				b_q     <= b_d;
				e2abs_q <= e2abs_d;
			end
			ST_EXP: begin
				ebcd_q <= ebcd_al;
				ne_q   <= ne_d;
			end
			ST_EMIT: begin
				if (emit_en) begin
					if (seg_q == SG_INT || seg_q == SG_FRAC) begin
						dig_q <= {dig_q[BCD_W-5:0], 4'd0};
					end
					if (seg_q == SG_EDIG) begin
						ebcd_q <= {ebcd_q[7:0], 4'd0};
					end
				end
			end
			default: ;
		endcase
	end

endmodule
